### rtl/i2c_write_read_sequencer_defines.svh
// assertion macros for the i2c write-then-read sequencer
`ifndef I2C_WRITE_READ_SEQUENCER_DEFINES_SVH
`define I2C_WRITE_READ_SEQUENCER_DEFINES_SVH

// same-cycle implication, checked while out of reset
`define IWRS_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("iwrs check failed");

// next-cycle implication, checked while out of reset
`define IWRS_ASSERT_IMPLY_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("iwrs check failed");

`endif

### rtl/iwrs_pkg.sv
// shared types, constants and helpers of the i2c write-then-read sequencer
`default_nettype none

package iwrs_pkg;

  localparam logic [7:0] LEN_MAX = 8'd255;

  // controller command bits
  localparam logic [3:0] CMD_NONE  = 4'b0000;
  localparam logic [3:0] CMD_RUN   = 4'b0001;
  localparam logic [3:0] CMD_START = 4'b0010;
  localparam logic [3:0] CMD_STOP  = 4'b0100;
  localparam logic [3:0] CMD_ACK   = 4'b1000;

  typedef enum logic [1:0] {
    REG_TARGET_ADDRESS = 2'd0,
    REG_WRITE_COUNT    = 2'd1,
    REG_READ_COUNT     = 2'd2
  } iwrs_reg_e;

  typedef enum logic {
    OP_BEGIN = 1'b0,
    OP_EVENT = 1'b1
  } iwrs_op_e;

  typedef struct packed {
    logic [6:0] target_address;
    logic [7:0] write_count;
    logic [7:0] read_count;
  } iwrs_cfg_t;

  typedef struct packed {
    logic       operation;
    logic       bus_error;
    logic [7:0] received_byte;
    logic [7:0] write_byte;
  } iwrs_item_t;

  typedef struct packed {
    logic       load_address;
    logic [7:0] address_byte;
    logic       load_data;
    logic [7:0] data_byte;
    logic [7:0] next_write_index;
    logic       store_read;
    logic [7:0] read_index;
    logic [7:0] read_data;
    logic [3:0] command;
    logic       done_res;
    logic       error_flag;
  } iwrs_result_t;

  // rd_started low stands for the read address not yet sent
  typedef struct packed {
    logic [7:0] wr_pos;
    logic       rd_started;
    logic [7:0] rd_pos;
    logic       sticky_err;
  } iwrs_state_t;

  function automatic logic [7:0] len_limit(input logic [7:0] n);
    len_limit = (n > LEN_MAX) ? LEN_MAX : n;
  endfunction

endpackage

`default_nettype wire

### rtl/iwrs_if.sv
// valid/ready channel interfaces of the i2c write-then-read sequencer
`default_nettype none

interface iwrs_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic       bus_error;
  logic [7:0] received_byte;
  logic [7:0] write_byte;

  modport source (output valid, operation, bus_error, received_byte, write_byte,
                  input ready);
  modport sink (input valid, operation, bus_error, received_byte, write_byte,
                output ready);
endinterface

interface iwrs_out_if;
  logic       valid;
  logic       ready;
  logic       load_address;
  logic [7:0] address_byte;
  logic       load_data;
  logic [7:0] data_byte;
  logic [7:0] next_write_index;
  logic       store_read;
  logic [7:0] read_index;
  logic [7:0] read_data;
  logic [3:0] command;
  logic       done_res;
  logic       error_flag;

  modport source (output valid, load_address, address_byte, load_data, data_byte,
                  next_write_index, store_read, read_index, read_data, command,
                  done_res, error_flag,
                  input ready);
  modport sink (input valid, load_address, address_byte, load_data, data_byte,
                next_write_index, store_read, read_index, read_data, command,
                done_res, error_flag,
                output ready);
endinterface

interface iwrs_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

### rtl/i2c_write_read_sequencer.sv
// I2C write-then-read sequencer (repeated start) for a byte-level controller
//
// Channels: in_i takes one word per begin or controller completion event,
// out_o gives one word per input word: the next controller command with the
// address and data bytes to load, the read byte to store, and done.
// cfg_i writes target_address (index 0), write_count (1), read_count (2);
// it is always ready and should be written only while the block is idle.
// An accepted word is held in the input register, and its result is then
// registered in the result register and shown on out_o.
// Throughput: one word per cycle while out_o does not stall, set by the single
// input register feeding the next-command logic and the result register; the
// transfer state is updated as the result is registered, so back-to-back words see it.
// Reset clears the configuration registers, the transfer state (write
// position 0, read address not yet sent, no error) and both valid flags.
// When out_o stalls, the result holds, one more word is taken into the
// input register, and then in_i.ready drops until out_o moves again.
`default_nettype none

module i2c_write_read_sequencer (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  iwrs_cfg_if.sink  cfg_i,
  iwrs_in_if.sink   in_i,
  iwrs_out_if.source out_o
);

  iwrs_pkg::iwrs_cfg_t    cfg;
  iwrs_pkg::iwrs_item_t   item_q;
  iwrs_pkg::iwrs_result_t res_q, res_d;
  iwrs_pkg::iwrs_state_t  state_q, state_d;
  logic                   in_valid_q;
  logic                   out_valid_q;
  logic                   advance;
  logic                   in_ready;

  iwrs_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  iwrs_step u_step (
    .cfg_i    (cfg),
    .state_i  (state_q),
    .item_i   (item_q),
    .result_o (res_d),
    .state_o  (state_d)
  );

  assign advance  = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_ready = !in_valid_q || advance;
  assign in_i.ready = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '{wr_pos: 8'd0, rd_started: 1'b0, rd_pos: 8'd0, sticky_err: 1'b0};
    end else begin
      if (in_ready) begin
        in_valid_q <= in_i.valid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && in_i.valid) begin
      item_q <= '{operation:     in_i.operation,
                  bus_error:     in_i.bus_error,
                  received_byte: in_i.received_byte,
                  write_byte:    in_i.write_byte};
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.load_address     = res_q.load_address;
  assign out_o.address_byte     = res_q.address_byte;
  assign out_o.load_data        = res_q.load_data;
  assign out_o.data_byte        = res_q.data_byte;
  assign out_o.next_write_index = res_q.next_write_index;
  assign out_o.store_read       = res_q.store_read;
  assign out_o.read_index       = res_q.read_index;
  assign out_o.read_data        = res_q.read_data;
  assign out_o.command          = res_q.command;
  assign out_o.done_res         = res_q.done_res;
  assign out_o.error_flag       = res_q.error_flag;

endmodule

`default_nettype wire

### rtl/iwrs_cfg_regs.sv
// configuration registers: target address, write count, read count
`default_nettype none

module iwrs_cfg_regs (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  iwrs_cfg_if.sink           cfg_i,
  output iwrs_pkg::iwrs_cfg_t cfg_o
);

  iwrs_pkg::iwrs_cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (cfg_i.index)
        iwrs_pkg::REG_TARGET_ADDRESS: cfg_d.target_address = cfg_i.data[6:0];
        iwrs_pkg::REG_WRITE_COUNT:    cfg_d.write_count    = cfg_i.data;
        iwrs_pkg::REG_READ_COUNT:     cfg_d.read_count     = cfg_i.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

### rtl/iwrs_step.sv
// next-command logic: one item and the transfer state give one result
`default_nettype none

module iwrs_step (
  input  iwrs_pkg::iwrs_cfg_t    cfg_i,
  input  iwrs_pkg::iwrs_state_t  state_i,
  input  iwrs_pkg::iwrs_item_t   item_i,
  output iwrs_pkg::iwrs_result_t result_o,
  output iwrs_pkg::iwrs_state_t  state_o
);

  logic [7:0]            wc;
  logic [7:0]            rc;
  iwrs_pkg::iwrs_state_t cur;
  iwrs_pkg::iwrs_state_t nxt;
  iwrs_pkg::iwrs_result_t res;
  logic [3:0]            start_bit;
  logic                  rx_done;

  assign wc = iwrs_pkg::len_limit(cfg_i.write_count);
  assign rc = iwrs_pkg::len_limit(cfg_i.read_count);

  always_comb begin
    cur = state_i;
    // begin word restarts the transfer
    if (item_i.operation == iwrs_pkg::OP_BEGIN) begin
      cur = '0;
    end
    nxt       = cur;
    res       = '0;
    start_bit = iwrs_pkg::CMD_NONE;
    rx_done   = 1'b0;

    if (cur.wr_pos < wc) begin
      if (cur.wr_pos == 8'd0) begin
        start_bit        = iwrs_pkg::CMD_START;
        res.load_address = 1'b1;
        res.address_byte = {cfg_i.target_address, 1'b0};
      end
      res.load_data = 1'b1;
      res.data_byte = item_i.write_byte;
      nxt.wr_pos    = cur.wr_pos + 8'd1;
      if (nxt.wr_pos < wc || rc != 8'd0) begin
        res.command = iwrs_pkg::CMD_RUN | start_bit;
      end else begin
        res.command = iwrs_pkg::CMD_STOP | iwrs_pkg::CMD_RUN | start_bit;
      end
    end else if (rc != 8'd0 && (!cur.rd_started || cur.rd_pos < rc)) begin
      if (!cur.rd_started) begin
        // repeated start with the read address
        start_bit        = iwrs_pkg::CMD_START;
        res.load_address = 1'b1;
        res.address_byte = {cfg_i.target_address, 1'b1};
        nxt.rd_started   = 1'b1;
        nxt.rd_pos       = 8'd0;
      end else begin
        res.store_read = 1'b1;
        res.read_index = cur.rd_pos;
        res.read_data  = item_i.received_byte;
        nxt.rd_pos     = cur.rd_pos + 8'd1;
      end
      if (nxt.rd_pos == rc) begin
        res.command = iwrs_pkg::CMD_STOP | iwrs_pkg::CMD_RUN | start_bit;
      end else begin
        res.command = iwrs_pkg::CMD_ACK | iwrs_pkg::CMD_RUN | start_bit;
      end
    end else begin
      rx_done      = (rc == 8'd0) || (cur.rd_started && cur.rd_pos == rc);
      res.done_res = (rx_done && cur.wr_pos == wc) || cur.sticky_err;
    end

    // done test above sees the error before this word's bit
    nxt.sticky_err       = cur.sticky_err | item_i.bus_error;
    res.next_write_index = nxt.wr_pos;
    res.error_flag       = nxt.sticky_err;
  end

  assign result_o = res;
  assign state_o  = nxt;

endmodule

`default_nettype wire

### rtl/iwrs_checker.sv
// port-level checks of the i2c write-then-read sequencer, bound to the top level
`default_nettype none
`include "i2c_write_read_sequencer_defines.svh"

module iwrs_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic       load_address_i,
  input wire logic [7:0] address_byte_i,
  input wire logic       load_data_i,
  input wire logic [7:0] data_byte_i,
  input wire logic       store_read_i,
  input wire logic [7:0] read_index_i,
  input wire logic [7:0] read_data_i,
  input wire logic [3:0] command_i,
  input wire logic       done_res_i
);

  // a stalled word stays and holds its command, address, data and read fields
  `IWRS_ASSERT_IMPLY_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(command_i) && $stable(address_byte_i) && $stable(data_byte_i) && $stable(read_index_i) && $stable(read_data_i))

  // done comes only with no command and nothing to load or store
  `IWRS_ASSERT_IMPLY(a_done_idle, clk_i, rst_ni, out_valid_i && done_res_i, command_i == iwrs_pkg::CMD_NONE && !load_address_i && !load_data_i && !store_read_i)

  // an address byte always goes out with start and run
  `IWRS_ASSERT_IMPLY(a_addr_start, clk_i, rst_ni, out_valid_i && load_address_i, (command_i & iwrs_pkg::CMD_START) != 4'd0 && (command_i & iwrs_pkg::CMD_RUN) != 4'd0)

  // storing a read byte never loads the controller and never restarts
  `IWRS_ASSERT_IMPLY(a_store_plain, clk_i, rst_ni, out_valid_i && store_read_i, !load_address_i && !load_data_i && (command_i & iwrs_pkg::CMD_START) == 4'd0 && (command_i & iwrs_pkg::CMD_RUN) != 4'd0)

endmodule

bind i2c_write_read_sequencer iwrs_checker u_iwrs_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .load_address_i (out_o.load_address),
  .address_byte_i (out_o.address_byte),
  .load_data_i    (out_o.load_data),
  .data_byte_i    (out_o.data_byte),
  .store_read_i   (out_o.store_read),
  .read_index_i   (out_o.read_index),
  .read_data_i    (out_o.read_data),
  .command_i      (out_o.command),
  .done_res_i     (out_o.done_res)
);

`default_nettype wire

### tb/sv/i2c_write_read_sequencer_tb.sv
// self-checking testbench: directed script then random transactions, scored per word
`timescale 1ns / 100ps

module i2c_write_read_sequencer_tb;

  localparam int ITEM_GOAL   = 1620;
  localparam int QUIET_FROM  = ITEM_GOAL - 200;
  localparam int PRESSURE_AT = 300;
  localparam int HOLD_CYCLES = 60;

  typedef enum bit {
    ROW_REG,
    ROW_WORD
  } row_kind_e;

  typedef struct {
    row_kind_e              kind;
    iwrs_pkg::iwrs_reg_e    reg_idx;
    logic [7:0]             reg_val;
    iwrs_pkg::iwrs_item_t   word;
    bit                     typed;
    iwrs_pkg::iwrs_result_t want;
  } script_row_t;

  logic clk_i;
  logic rst_ni;

  iwrs_cfg_if cfg_ch ();
  iwrs_in_if  in_ch ();
  iwrs_out_if out_ch ();

  i2c_write_read_sequencer i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_ch),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  // shadow of the block's registers and transfer state
  iwrs_pkg::iwrs_cfg_t reg_shadow;
  logic [7:0]          sent_count;
  int                  read_pos;
  logic                fault_seen;

  iwrs_pkg::iwrs_result_t command_q[$];
  script_row_t            script[$];
  int                     items_sent;
  int                     results_seen;
  int                     error_count;
  bit                     idle_mode;
  bit                     hold_request;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  initial begin : watchdog
    #5_000_000;
    $display("i2c_write_read_sequencer_tb NOT OK");
    $finish;
  end

  // next controller command for one accepted word, advances the shadow state
  function automatic iwrs_pkg::iwrs_result_t next_command(input iwrs_pkg::iwrs_item_t w);
    iwrs_pkg::iwrs_result_t r;
    int                     wr_total;
    int                     rd_total;
    logic [3:0]             start_bit;
    r         = '0;
    start_bit = iwrs_pkg::CMD_NONE;
    wr_total  = (reg_shadow.write_count > iwrs_pkg::LEN_MAX) ? int'(iwrs_pkg::LEN_MAX)
                                                             : int'(reg_shadow.write_count);
    rd_total  = (reg_shadow.read_count > iwrs_pkg::LEN_MAX) ? int'(iwrs_pkg::LEN_MAX)
                                                            : int'(reg_shadow.read_count);
    if (w.operation == iwrs_pkg::OP_BEGIN) begin
      sent_count = '0;
      read_pos   = -1;
      fault_seen = 1'b0;
    end
    if (int'(sent_count) < wr_total) begin
      if (sent_count == 8'd0) begin
        start_bit      = iwrs_pkg::CMD_START;
        r.load_address = 1'b1;
        r.address_byte = {reg_shadow.target_address, 1'b0};
      end
      r.load_data = 1'b1;
      r.data_byte = w.write_byte;
      sent_count  = sent_count + 8'd1;
      if (int'(sent_count) < wr_total || rd_total != 0)
        r.command = iwrs_pkg::CMD_RUN | start_bit;
      else
        r.command = iwrs_pkg::CMD_STOP | iwrs_pkg::CMD_RUN | start_bit;
    end else if (rd_total > 0 && read_pos < rd_total) begin
      if (read_pos < 0) begin
        // repeated start with the read address
        start_bit      = iwrs_pkg::CMD_START;
        r.load_address = 1'b1;
        r.address_byte = {reg_shadow.target_address, 1'b1};
        read_pos       = 0;
      end else begin
        r.store_read = 1'b1;
        r.read_index = read_pos[7:0];
        r.read_data  = w.received_byte;
        read_pos     = read_pos + 1;
      end
      if (read_pos == rd_total)
        r.command = iwrs_pkg::CMD_STOP | iwrs_pkg::CMD_RUN | start_bit;
      else
        r.command = iwrs_pkg::CMD_ACK | iwrs_pkg::CMD_RUN | start_bit;
    end else begin
      // done test uses the error held before this word
      if (((rd_total == 0 || read_pos == rd_total) && int'(sent_count) == wr_total) ||
          fault_seen)
        r.done_res = 1'b1;
    end
    fault_seen         = fault_seen | w.bus_error;
    r.next_write_index = sent_count;
    r.error_flag       = fault_seen;
    return r;
  endfunction

  function automatic iwrs_pkg::iwrs_item_t make_word(input logic op, input logic berr,
                                                     input logic [7:0] rbyte,
                                                     input logic [7:0] wbyte);
    iwrs_pkg::iwrs_item_t w;
    w.operation     = op;
    w.bus_error     = berr;
    w.received_byte = rbyte;
    w.write_byte    = wbyte;
    return w;
  endfunction

  function automatic iwrs_pkg::iwrs_item_t rand_word(input logic op);
    return make_word(op, $urandom_range(0, 19) == 0, 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)));
  endfunction

  function automatic iwrs_pkg::iwrs_result_t result_of(
    input logic la, input logic [7:0] ab, input logic ld, input logic [7:0] db,
    input logic [7:0] nwi, input logic sr, input logic [7:0] ri, input logic [7:0] rd,
    input logic [3:0] cmd, input logic done, input logic err);
    iwrs_pkg::iwrs_result_t r;
    r.load_address     = la;
    r.address_byte     = ab;
    r.load_data        = ld;
    r.data_byte        = db;
    r.next_write_index = nwi;
    r.store_read       = sr;
    r.read_index       = ri;
    r.read_data        = rd;
    r.command          = cmd;
    r.done_res         = done;
    r.error_flag       = err;
    return r;
  endfunction

  function automatic script_row_t blank_row();
    script_row_t row;
    row.kind    = ROW_WORD;
    row.reg_idx = iwrs_pkg::REG_TARGET_ADDRESS;
    row.reg_val = '0;
    row.word    = '0;
    row.typed   = 1'b0;
    row.want    = '0;
    return row;
  endfunction

  function automatic void add_reg(input iwrs_pkg::iwrs_reg_e idx, input logic [7:0] v);
    script_row_t row;
    row         = blank_row();
    row.kind    = ROW_REG;
    row.reg_idx = idx;
    row.reg_val = v;
    script.push_back(row);
  endfunction

  function automatic void add_word(input logic op, input logic berr,
                                   input logic [7:0] rbyte, input logic [7:0] wbyte);
    script_row_t row;
    row      = blank_row();
    row.kind = ROW_WORD;
    row.word = make_word(op, berr, rbyte, wbyte);
    script.push_back(row);
  endfunction

  function automatic void add_checked(input logic op, input logic berr,
                                      input logic [7:0] rbyte, input logic [7:0] wbyte,
                                      input iwrs_pkg::iwrs_result_t want);
    add_word(op, berr, rbyte, wbyte);
    script[$].typed = 1'b1;
    script[$].want  = want;
  endfunction

  function automatic void build_script();
    // after reset: nothing configured, events report done
    add_checked(iwrs_pkg::OP_EVENT, 1'b0, 8'h00, 8'h00,
                result_of(0, 8'h00, 0, 8'h00, 8'd0, 0, 8'd0, 8'h00,
                          iwrs_pkg::CMD_NONE, 1, 0));
    add_checked(iwrs_pkg::OP_EVENT, 1'b1, 8'hFF, 8'hFF,
                result_of(0, 8'h00, 0, 8'h00, 8'd0, 0, 8'd0, 8'h00,
                          iwrs_pkg::CMD_NONE, 1, 1));
    add_checked(iwrs_pkg::OP_BEGIN, 1'b0, 8'h00, 8'h00,
                result_of(0, 8'h00, 0, 8'h00, 8'd0, 0, 8'd0, 8'h00,
                          iwrs_pkg::CMD_NONE, 1, 0));
    // one write, two reads at the top address
    add_reg(iwrs_pkg::REG_TARGET_ADDRESS, 8'd127);
    add_reg(iwrs_pkg::REG_WRITE_COUNT, 8'd1);
    add_reg(iwrs_pkg::REG_READ_COUNT, 8'd2);
    add_checked(iwrs_pkg::OP_BEGIN, 1'b0, 8'h55, 8'hFF,
                result_of(1, 8'hFE, 1, 8'hFF, 8'd1, 0, 8'd0, 8'h00,
                          iwrs_pkg::CMD_RUN | iwrs_pkg::CMD_START, 0, 0));
    add_checked(iwrs_pkg::OP_EVENT, 1'b0, 8'h00, 8'h00,
                result_of(1, 8'hFF, 0, 8'h00, 8'd1, 0, 8'd0, 8'h00,
                          iwrs_pkg::CMD_ACK | iwrs_pkg::CMD_RUN | iwrs_pkg::CMD_START,
                          0, 0));
    add_checked(iwrs_pkg::OP_EVENT, 1'b0, 8'hFF, 8'h00,
                result_of(0, 8'h00, 0, 8'h00, 8'd1, 1, 8'd0, 8'hFF,
                          iwrs_pkg::CMD_ACK | iwrs_pkg::CMD_RUN, 0, 0));
    add_checked(iwrs_pkg::OP_EVENT, 1'b0, 8'h00, 8'hFF,
                result_of(0, 8'h00, 0, 8'h00, 8'd1, 1, 8'd1, 8'h00,
                          iwrs_pkg::CMD_STOP | iwrs_pkg::CMD_RUN, 0, 0));
    add_checked(iwrs_pkg::OP_EVENT, 1'b0, 8'h12, 8'h34,
                result_of(0, 8'h00, 0, 8'h00, 8'd1, 0, 8'd0, 8'h00,
                          iwrs_pkg::CMD_NONE, 1, 0));
    // write count lowered under the position: stuck until an error is held
    add_reg(iwrs_pkg::REG_WRITE_COUNT, 8'd0);
    add_checked(iwrs_pkg::OP_EVENT, 1'b0, 8'h00, 8'h00,
                result_of(0, 8'h00, 0, 8'h00, 8'd1, 0, 8'd0, 8'h00,
                          iwrs_pkg::CMD_NONE, 0, 0));
    add_checked(iwrs_pkg::OP_EVENT, 1'b1, 8'h00, 8'h00,
                result_of(0, 8'h00, 0, 8'h00, 8'd1, 0, 8'd0, 8'h00,
                          iwrs_pkg::CMD_NONE, 0, 1));
    add_checked(iwrs_pkg::OP_EVENT, 1'b0, 8'h00, 8'h00,
                result_of(0, 8'h00, 0, 8'h00, 8'd1, 0, 8'd0, 8'h00,
                          iwrs_pkg::CMD_NONE, 1, 1));
    // read only, error raised on the begin word itself
    add_reg(iwrs_pkg::REG_READ_COUNT, 8'd1);
    add_word(iwrs_pkg::OP_BEGIN, 1'b1, 8'h00, 8'h3C);
    add_word(iwrs_pkg::OP_EVENT, 1'b0, 8'hAA, 8'hC3);
    add_word(iwrs_pkg::OP_EVENT, 1'b0, 8'h5A, 8'hA5);
    // write only at address zero, restarted mid-transfer
    add_reg(iwrs_pkg::REG_TARGET_ADDRESS, 8'd0);
    add_reg(iwrs_pkg::REG_WRITE_COUNT, 8'd2);
    add_reg(iwrs_pkg::REG_READ_COUNT, 8'd0);
    add_word(iwrs_pkg::OP_BEGIN, 1'b0, 8'hFF, 8'h81);
    add_word(iwrs_pkg::OP_BEGIN, 1'b0, 8'h00, 8'h7E);
    add_word(iwrs_pkg::OP_EVENT, 1'b0, 8'h00, 8'h00);
    add_word(iwrs_pkg::OP_EVENT, 1'b1, 8'hFF, 8'hFF);
    add_word(iwrs_pkg::OP_EVENT, 1'b0, 8'h0F, 8'hF0);
  endfunction

  task automatic flag_error(input string what);
    if (error_count < 100)
      $display("ERROR at %0t: %s", $time, what);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want)
      flag_error($sformatf("word %0d %s: want %0h got %0h", results_seen, name, want, got));
  endtask

  function automatic bit bursts_on();
    return idle_mode && items_sent < QUIET_FROM;
  endfunction

  task automatic write_reg(input iwrs_pkg::iwrs_reg_e idx, input logic [7:0] v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= v;
    do @(posedge clk_i); while (cfg_ch.ready !== 1'b1);
    case (idx)
      iwrs_pkg::REG_TARGET_ADDRESS: reg_shadow.target_address = v[6:0];
      iwrs_pkg::REG_WRITE_COUNT:    reg_shadow.write_count = v;
      iwrs_pkg::REG_READ_COUNT:     reg_shadow.read_count = v;
      default: ;
    endcase
    cfg_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_word(input iwrs_pkg::iwrs_item_t w, input bit typed,
                           input iwrs_pkg::iwrs_result_t want);
    iwrs_pkg::iwrs_result_t predicted;
    in_ch.valid         <= 1'b1;
    in_ch.operation     <= w.operation;
    in_ch.bus_error     <= w.bus_error;
    in_ch.received_byte <= w.received_byte;
    in_ch.write_byte    <= w.write_byte;
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
    predicted = next_command(w);
    command_q.push_back(typed ? want : predicted);
    items_sent++;
    if (items_sent == PRESSURE_AT)
      hold_request = 1'b1;
    if (bursts_on() && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
  endtask

  // every word gives a result, so an empty queue means the block is idle
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (command_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin : score_results
    iwrs_pkg::iwrs_result_t got;
    iwrs_pkg::iwrs_result_t want;
    if (rst_ni === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got.load_address     = out_ch.load_address;
      got.address_byte     = out_ch.address_byte;
      got.load_data        = out_ch.load_data;
      got.data_byte        = out_ch.data_byte;
      got.next_write_index = out_ch.next_write_index;
      got.store_read       = out_ch.store_read;
      got.read_index       = out_ch.read_index;
      got.read_data        = out_ch.read_data;
      got.command          = out_ch.command;
      got.done_res         = out_ch.done_res;
      got.error_flag       = out_ch.error_flag;
      if (command_q.size() == 0) begin
        flag_error($sformatf("result word %0d with nothing expected", results_seen));
      end else begin
        want = command_q.pop_front();
        check_field("load_address", 8'(want.load_address), 8'(got.load_address));
        check_field("address_byte", want.address_byte, got.address_byte);
        check_field("load_data", 8'(want.load_data), 8'(got.load_data));
        check_field("data_byte", want.data_byte, got.data_byte);
        check_field("next_write_index", want.next_write_index, got.next_write_index);
        check_field("store_read", 8'(want.store_read), 8'(got.store_read));
        check_field("read_index", want.read_index, got.read_index);
        check_field("read_data", want.read_data, got.read_data);
        check_field("command", 8'(want.command), 8'(got.command));
        check_field("done_res", 8'(want.done_res), 8'(got.done_res));
        check_field("error_flag", 8'(want.error_flag), 8'(got.error_flag));
      end
      results_seen++;
    end
  end

  initial begin : result_sink
    out_ch.ready <= 1'b0;
    forever begin
      if (hold_request) begin
        // long hold-off so the block backs up into its input
        hold_request = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else if (bursts_on() && $urandom_range(0, 7) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  initial begin : stimulus
    int                     phase;
    int                     n_tx;
    int                     n_ev;
    int                     kind;
    iwrs_pkg::iwrs_result_t no_result;
    no_result           = '0;
    items_sent          = 0;
    results_seen        = 0;
    error_count         = 0;
    idle_mode           = 1'b1;
    hold_request        = 1'b0;
    reg_shadow          = '0;
    sent_count          = '0;
    read_pos            = -1;
    fault_seen          = 1'b0;
    rst_ni              <= 1'b0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.index        <= '0;
    cfg_ch.data         <= '0;
    in_ch.valid         <= 1'b0;
    in_ch.operation     <= 1'b0;
    in_ch.bus_error     <= 1'b0;
    in_ch.received_byte <= '0;
    in_ch.write_byte    <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    build_script();
    foreach (script[i]) begin
      if (script[i].kind == ROW_REG) begin
        wait_idle();
        write_reg(script[i].reg_idx, script[i].reg_val);
      end else begin
        send_word(script[i].word, script[i].typed, script[i].want);
      end
    end

    // random phases; the first two run one full transfer at write count 255, the first also at read count 255
    phase = 0;
    while (items_sent < ITEM_GOAL) begin
      wait_idle();
      case (phase)
        0: begin
          write_reg(iwrs_pkg::REG_TARGET_ADDRESS, 8'($urandom_range(0, 127)));
          write_reg(iwrs_pkg::REG_WRITE_COUNT, 8'd255);
          write_reg(iwrs_pkg::REG_READ_COUNT, 8'd255);
        end
        1: begin
          write_reg(iwrs_pkg::REG_TARGET_ADDRESS, 8'd0);
          write_reg(iwrs_pkg::REG_WRITE_COUNT, 8'd255);
          write_reg(iwrs_pkg::REG_READ_COUNT, 8'd0);
        end
        2: begin
          write_reg(iwrs_pkg::REG_TARGET_ADDRESS, 8'd127);
          write_reg(iwrs_pkg::REG_WRITE_COUNT, 8'd0);
          write_reg(iwrs_pkg::REG_READ_COUNT, 8'd0);
        end
        default: begin
          write_reg(iwrs_pkg::REG_TARGET_ADDRESS, 8'($urandom_range(0, 127)));
          write_reg(iwrs_pkg::REG_WRITE_COUNT, 8'($urandom_range(0, 6)));
          write_reg(iwrs_pkg::REG_READ_COUNT, 8'($urandom_range(0, 6)));
        end
      endcase
      idle_mode = ($urandom_range(0, 3) != 0);
      n_tx = (phase < 2) ? 1 : $urandom_range(3, 8);
      repeat (n_tx) begin
        kind = (phase < 2) ? 2 : $urandom_range(0, 9);
        if (kind == 0) begin
          repeat ($urandom_range(1, 4))
            send_word(rand_word(1'($urandom_range(0, 1))), 1'b0, no_result);
        end else begin
          send_word(rand_word(iwrs_pkg::OP_BEGIN), 1'b0, no_result);
          n_ev = int'(reg_shadow.write_count) + int'(reg_shadow.read_count) + 1;
          // broken transfers stop short, well-formed ones may poll past done
          if (kind == 1)
            n_ev = $urandom_range(0, n_ev - 1);
          else
            n_ev = n_ev + $urandom_range(0, 1);
          repeat (n_ev) send_word(rand_word(iwrs_pkg::OP_EVENT), 1'b0, no_result);
        end
      end
      phase++;
    end

    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (command_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (error_count == 0) begin
      $display("i2c_write_read_sequencer_tb OK");
    end else begin
      $display("i2c_write_read_sequencer_tb NOT OK");
    end
    $finish;
  end

endmodule
